/* rtl/fchm_pkg.sv */
// Shared constants, types and register codes of the frame count histogram block.
package fchm_pkg;

  localparam int unsigned BINS       = 64;
  localparam int unsigned BIN_BITS   = $clog2(BINS);
  localparam int unsigned FRAME_BITS = 24;
  localparam int unsigned VALUE_BITS = 16;

  // Configuration port: one index bit selects one of the two registers.
  localparam int unsigned CFG_IDX_BITS  = 1;
  localparam int unsigned CFG_DATA_BITS = VALUE_BITS;

  localparam logic [BIN_BITS-1:0]   TALLY_MAX = BIN_BITS'(BINS - 1);
  localparam logic [FRAME_BITS-1:0] BIN_MAX   = '1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_THRESHOLD = 1'b0,
    REG_COMPARE   = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_LAST,
    ST_SCAN,
    ST_DRAIN
  } state_e;

  // One histogram bin read by the mode scan, aligned with the read data.
  typedef struct packed {
    logic                vld;
    logic [BIN_BITS-1:0] bin;
  } scan_tap_t;

  // Best bin found so far and how many frames it holds.
  typedef struct packed {
    logic [BIN_BITS-1:0]   bin;
    logic [FRAME_BITS-1:0] frames;
  } mode_t;

endpackage

/* rtl/frame_count_histogram_mode.sv */
// Top level of the per-frame labelled count histogram with mode readout.
//
// Usage: table rows enter on start_i with frame_id_i, value_i and last_row_i.
// A row is accepted at a rising edge where start_i is high and busy_o is low.
// Each row is labelled by comparing value_i with the threshold register,
// either greater-than or less-or-equal, and labelled rows are counted per
// frame. When the frame id changes, the finished frame adds one to the
// histogram bin of its count through a read-modify-write of the bin memory.
// While rows stream, one row is accepted every cycle.
// The row with last_row_i set closes the final frame and raises busy_o
// while the block issues the final frame's update, then the one memory
// read port walks the bins from 63 down to 0, and then a last step
// finishes the compare. In the cycle in which busy_o falls, result_valid_o is
// high for exactly one cycle with mode_count_o, frames_at_mode_o and
// count_overflow_o; the receiver cannot hold that transaction off. The
// histogram is cleared at once by its valid bits, so the next table may
// start in that same cycle. Reset clears the run state, sets the threshold
// to zero and selects the greater-than compare. Configuration is written
// through cfg_we_i, cfg_idx_i and cfg_data_i while no table is in flight.
module frame_count_histogram_mode (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [fchm_pkg::FRAME_BITS-1:0]     frame_id_i,
  input  logic [fchm_pkg::VALUE_BITS-1:0]     value_i,
  input  logic                                last_row_i,
  input  logic                                cfg_we_i,
  input  logic [fchm_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [fchm_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  output logic                                result_valid_o,
  output logic [fchm_pkg::BIN_BITS-1:0]       mode_count_o,
  output logic [fchm_pkg::FRAME_BITS-1:0]     frames_at_mode_o,
  output logic                                count_overflow_o
);
  import fchm_pkg::*;

  state_e state_q, state_d;

  logic [VALUE_BITS-1:0] thr_q;
  logic                  cmp_q;
  logic [FRAME_BITS-1:0] cur_frame_q;
  logic [BIN_BITS-1:0]   tally_q;
  logic                  first_q;
  logic                  ovf_q;
  logic [BIN_BITS-1:0]   final_bin_q;
  logic [BIN_BITS-1:0]   scan_q;
  logic                  b_vld_q;
  logic [BIN_BITS-1:0]   b_bin_q;
  scan_tap_t             tap_q, tap_d;
  logic                  out_vld_q;
  mode_t                 out_mode_q;
  logic                  out_ovf_q;

  logic                  accept;
  logic                  labelled;
  logic                  frame_change;
  logic [BIN_BITS-1:0]   tally_base;
  logic [BIN_BITS-1:0]   tally_next;
  logic                  issue_last;
  logic                  scan_issue;
  logic                  drain;
  logic                  close_req;
  logic                  rd_en;
  logic [BIN_BITS-1:0]   rd_addr;
  logic [FRAME_BITS-1:0] hist_cur;
  logic [FRAME_BITS-1:0] hist_inc;
  mode_t                 scan_mode;

  assign accept = start_i && (state_q == ST_RUN);
  assign busy_o = (state_q != ST_RUN);

  // Row labelling and per-frame tally. The first row of a run opens a frame
  // without closing an empty one.
  assign labelled     = cmp_q ? (value_i > thr_q) : (value_i <= thr_q);
  assign frame_change = !first_q && (frame_id_i != cur_frame_q);
  assign tally_base   = (first_q || frame_change) ? '0 : tally_q;

  always_comb begin
    tally_next = tally_base;
    if (labelled && (tally_base != TALLY_MAX)) begin
      tally_next = tally_base + BIN_BITS'(1);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_RUN: begin
        if (accept && last_row_i) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_q == '0) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_RUN;
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  // Controls decoded from the state.
  always_comb begin
    issue_last = 1'b0;
    scan_issue = 1'b0;
    drain      = 1'b0;
    case (state_q)
      ST_RUN:   ;
      ST_LAST:  issue_last = 1'b1;
      ST_SCAN:  scan_issue = 1'b1;
      ST_DRAIN: drain = 1'b1;
      default:  ;
    endcase
  end

  // One memory read per cycle: a frame close, the final close, or a scan step.
  assign close_req = (accept && frame_change) || issue_last;
  assign rd_en     = close_req || scan_issue;

  always_comb begin
    if (accept && frame_change) begin
      rd_addr = tally_q;
    end else if (issue_last) begin
      rd_addr = final_bin_q;
    end else begin
      rd_addr = scan_q;
    end
  end

  assign tap_d.vld = scan_issue;
  assign tap_d.bin = scan_q;

  // The bin count stops at its largest value.
  assign hist_inc = (hist_cur == BIN_MAX) ? hist_cur : hist_cur + FRAME_BITS'(1);

  fchm_hist_mem u_hist_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (hist_cur),
    .wr_en_i   (b_vld_q),
    .wr_addr_i (b_bin_q),
    .wr_data_i (hist_inc),
    .clr_i     (drain)
  );

  fchm_mode_scan u_mode_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tap_i   (tap_q),
    .value_i (hist_cur),
    .mode_o  (scan_mode)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      thr_q   <= '0;
      cmp_q   <= 1'b1;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_THRESHOLD: thr_q <= cfg_data_i[VALUE_BITS-1:0];
          REG_COMPARE:   cmp_q <= cfg_data_i[0];
          default:       ;
        endcase
      end
    end
  end

  // Run state: open frame id and tally, first-row flag, overflow flag and final bin.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_frame_q <= '0;
      tally_q     <= '0;
      first_q     <= 1'b1;
      ovf_q       <= 1'b0;
      final_bin_q <= '0;
    end else if (drain) begin
      cur_frame_q <= '0;
      tally_q     <= '0;
      first_q     <= 1'b1;
      ovf_q       <= 1'b0;
    end else if (accept) begin
      cur_frame_q <= frame_id_i;
      tally_q     <= tally_next;
      first_q     <= 1'b0;
      if (labelled && (tally_base == TALLY_MAX)) begin
        ovf_q <= 1'b1;
      end
      if (last_row_i) begin
        final_bin_q <= tally_next;
      end
    end
  end

  // Update pipeline and scan counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
      b_bin_q <= '0;
      tap_q   <= '0;
      scan_q  <= '0;
    end else begin
      b_vld_q <= close_req;
      b_bin_q <= rd_addr;
      tap_q   <= tap_d;
      if (issue_last) begin
        scan_q <= TALLY_MAX;
      end else if (scan_issue) begin
        scan_q <= scan_q - BIN_BITS'(1);
      end
    end
  end

  // Result register: one strobe per table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= drain;
    end
  end

  always_ff @(posedge clk_i) begin
    if (drain) begin
      out_mode_q <= scan_mode;
      out_ovf_q  <= ovf_q;
    end
  end

  assign result_valid_o   = out_vld_q;
  assign mode_count_o     = out_mode_q.bin;
  assign frames_at_mode_o = out_mode_q.frames;
  assign count_overflow_o = out_ovf_q;

endmodule

/* rtl/fchm_hist_mem.sv */
// Histogram memory with per-bin valid bits and write-to-read forwarding.
module fchm_hist_mem (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              rd_en_i,
  input  logic [fchm_pkg::BIN_BITS-1:0]     rd_addr_i,
  output logic [fchm_pkg::FRAME_BITS-1:0]   rd_data_o,
  input  logic                              wr_en_i,
  input  logic [fchm_pkg::BIN_BITS-1:0]     wr_addr_i,
  input  logic [fchm_pkg::FRAME_BITS-1:0]   wr_data_i,
  input  logic                              clr_i
);
  import fchm_pkg::*;

  logic [FRAME_BITS-1:0] mem_q [BINS];
  logic [FRAME_BITS-1:0] rdata_q;
  logic [BINS-1:0]       valid_q;
  logic                  rvld_q;
  logic [BIN_BITS-1:0]   raddr_q;
  logic                  lw_vld_q;
  logic [BIN_BITS-1:0]   lw_addr_q;
  logic [FRAME_BITS-1:0] lw_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      lw_addr_q <= wr_addr_i;
      lw_data_q <= wr_data_i;
    end
    if (rd_en_i) begin
      raddr_q <= rd_addr_i;
    end
  end

  // A bin that is not valid reads as zero, so clearing the valid bits clears the run.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvld_q   <= 1'b0;
      lw_vld_q <= 1'b0;
    end else begin
      lw_vld_q <= wr_en_i;
      if (rd_en_i) begin
        rvld_q <= valid_q[rd_addr_i];
      end
      if (clr_i) begin
        valid_q <= '0;
      end else if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  // A write landing on the same edge as the read of that bin is forwarded.
  assign rd_data_o = (lw_vld_q && (lw_addr_q == raddr_q)) ? lw_data_q :
                     (rvld_q ? rdata_q : '0);

endmodule

/* rtl/fchm_mode_scan.sv */
// Running maximum over histogram bins read from the highest bin down.
module fchm_mode_scan (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fchm_pkg::scan_tap_t             tap_i,
  input  logic [fchm_pkg::FRAME_BITS-1:0] value_i,
  output fchm_pkg::mode_t                 mode_o
);
  import fchm_pkg::*;

  mode_t best_q;
  logic  take;

  // The first bin read always starts the search; later bins win only when
  // strictly larger, so ties stay with the larger count.
  assign take = tap_i.vld && ((tap_i.bin == TALLY_MAX) || (value_i > best_q.frames));

  always_comb begin
    mode_o = best_q;
    if (take) begin
      mode_o.bin    = tap_i.bin;
      mode_o.frames = value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
    end else if (tap_i.vld) begin
      best_q <= mode_o;
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the frame count histogram block with mode readout.
module testbench;
  import fchm_pkg::*;

  // The clock period is 12 ns, and reset is held low at the start of the run.
  localparam int unsigned RESET_CYCLES = 5;
  // After the last row of a table, busy stays high while the block closes the final
  // frame and scans the bins, and the result is shown as busy falls. The settle pause covers that with some margin.
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned ROWS_PER_PHASE = 300;

  // One table row as the block takes it.
  typedef struct packed {
    logic [FRAME_BITS-1:0] frame_id;
    logic [VALUE_BITS-1:0] value;
    logic                  last_row;
  } table_row_t;

  // One mode readout as the block emits it at the end of a table.
  typedef struct packed {
    logic [BIN_BITS-1:0]   mode_count;
    logic [FRAME_BITS-1:0] frames_at_mode;
    logic                  count_overflow;
  } mode_readout_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start_i = 1'b0;
  logic                     busy_o;
  logic [FRAME_BITS-1:0]    frame_id_i = '0;
  logic [VALUE_BITS-1:0]    value_i = '0;
  logic                     last_row_i = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i = REG_THRESHOLD;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;
  logic                     result_valid_o;
  logic [BIN_BITS-1:0]      mode_count_o;
  logic [FRAME_BITS-1:0]    frames_at_mode_o;
  logic                     count_overflow_o;

  frame_count_histogram_mode uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .frame_id_i       (frame_id_i),
    .value_i          (value_i),
    .last_row_i       (last_row_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .result_valid_o   (result_valid_o),
    .mode_count_o     (mode_count_o),
    .frames_at_mode_o (frames_at_mode_o),
    .count_overflow_o (count_overflow_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Rows waiting to be offered to the block, and the readouts that the
  // accepted rows have earned so far, oldest first.
  table_row_t    pending_rows[$];
  mode_readout_t mode_readouts_due[$];
  table_row_t    row_on_port;

  // Our own copy of the block's registers, at their reset values.
  logic [VALUE_BITS-1:0] label_threshold = '0;
  logic                  label_above = 1'b1;

  // Our own copy of the run state of the histogram.
  logic [FRAME_BITS-1:0] frame_hist [BINS];
  logic [FRAME_BITS-1:0] open_frame;
  logic [BIN_BITS-1:0]   open_tally;
  logic                  awaiting_first_row;
  logic                  tally_saturated;

  int unsigned sender_idle_pct = 0;
  int unsigned rows_accepted = 0;
  int unsigned readouts_checked = 0;
  int unsigned overflow_readouts = 0;
  int unsigned settings_used = 1;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned rows_built = 0;

  task automatic report_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
    mismatches++;
    $display("mismatch at %0t: %s, expected %0d, got %0d", $realtime, what, want, got);
  endtask

  // Start a new table: empty histogram, no frame open yet.
  task automatic clear_run_state();
    foreach (frame_hist[b]) frame_hist[b] = '0;
    open_frame         = '0;
    open_tally         = '0;
    awaiting_first_row = 1'b1;
    tally_saturated    = 1'b0;
  endtask

  // A finished frame adds one to the bin of its labelled count; a bin never
  // wraps past its all-ones value.
  task automatic close_open_frame();
    if (frame_hist[open_tally] != BIN_MAX) frame_hist[open_tally]++;
  endtask

  // Predict the effect of one accepted row. The row that ends a table closes
  // its frame, then the bins are scanned from the top down so that a tie
  // goes to the larger count, and the readout is queued.
  task automatic tally_row(input table_row_t row);
    logic          labelled;
    mode_readout_t readout;
    labelled = label_above ? (row.value > label_threshold) : (row.value <= label_threshold);
    if (awaiting_first_row) begin
      awaiting_first_row = 1'b0;
      open_frame = row.frame_id;
      open_tally = '0;
    end else if (row.frame_id != open_frame) begin
      // Any change of id starts a new frame, even an id seen earlier.
      close_open_frame();
      open_frame = row.frame_id;
      open_tally = '0;
    end
    if (labelled) begin
      if (open_tally == TALLY_MAX) tally_saturated = 1'b1;
      else open_tally++;
    end
    if (row.last_row) begin
      close_open_frame();
      readout.mode_count     = TALLY_MAX;
      readout.frames_at_mode = frame_hist[BINS-1];
      for (int b = BINS - 2; b >= 0; b--) begin
        if (frame_hist[b] > readout.frames_at_mode) begin
          readout.mode_count     = BIN_BITS'(b);
          readout.frames_at_mode = frame_hist[b];
        end
      end
      readout.count_overflow = tally_saturated;
      mode_readouts_due.push_back(readout);
      clear_run_state();
    end
  endtask

  // Driver. A transaction completes at an edge where start_i is high and
  // busy_o is low; the next row is then put on the port unless the sender
  // decides to idle this cycle. While busy_o holds a row off it stays put.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        tally_row(row_on_port);
        rows_accepted++;
      end
      if (!start_i || !busy_o) begin
        if (pending_rows.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          row_on_port = pending_rows.pop_front();
          frame_id_i <= row_on_port.frame_id;
          value_i    <= row_on_port.value;
          last_row_i <= row_on_port.last_row;
          start_i    <= 1'b1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor. A readout is valid for exactly one cycle and cannot be held
  // off, so every strobe is checked against the oldest expected readout.
  always @(posedge clk_i) begin
    mode_readout_t want;
    if (rst_ni && result_valid_o) begin
      if (mode_readouts_due.size() == 0) begin
        report_mismatch("readout with none pending", 64'd0, 64'd1);
      end else begin
        want = mode_readouts_due.pop_front();
        readouts_checked++;
        if (count_overflow_o) overflow_readouts++;
        if (mode_count_o !== want.mode_count)
          report_mismatch("mode_count", 64'(want.mode_count), 64'(mode_count_o));
        if (frames_at_mode_o !== want.frames_at_mode)
          report_mismatch("frames_at_mode", 64'(want.frames_at_mode),
                          64'(frames_at_mode_o));
        if (count_overflow_o !== want.count_overflow)
          report_mismatch("count_overflow", 64'(want.count_overflow),
                          64'(count_overflow_o));
      end
    end
  end

  // Watchdog: a hang or a lost readout ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d readouts outstanding", cycle_count,
               mode_readouts_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic queue_row(input logic [FRAME_BITS-1:0] frame_id,
                           input logic [VALUE_BITS-1:0] value, input logic last_row);
    table_row_t row;
    row.frame_id = frame_id;
    row.value    = value;
    row.last_row = last_row;
    pending_rows.push_back(row);
    rows_built++;
  endtask

  // Values cluster on the threshold and its neighbors so that both labels
  // and the equality edge of each compare show up often.
  function automatic logic [VALUE_BITS-1:0] pick_value();
    logic [VALUE_BITS-1:0] v;
    case ($urandom_range(5))
      0: v = label_threshold;
      1: v = label_threshold + VALUE_BITS'(1);
      2: v = label_threshold - VALUE_BITS'(1);
      3: v = $urandom_range(1) ? '1 : '0;
      default: v = VALUE_BITS'($urandom);
    endcase
    return v;
  endfunction

  // One random table. Frames are mostly short so that counts collide and the
  // tie rule matters; now and then a long frame pushes the count into
  // saturation. Frame ids mostly step by one but sometimes jump, and
  // sometimes return to the table's first id to make an ungrouped frame.
  task automatic build_table(input int unsigned frames);
    logic [FRAME_BITS-1:0] frame_id;
    logic [FRAME_BITS-1:0] first_id;
    int unsigned           rows;
    frame_id = ($urandom_range(3) == 0) ? '1 - FRAME_BITS'($urandom_range(3))
                                        : FRAME_BITS'($urandom);
    first_id = frame_id;
    for (int unsigned f = 0; f < frames; f++) begin
      rows = ($urandom_range(24) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
      for (int unsigned k = 0; k < rows; k++)
        queue_row(frame_id, pick_value(), (f == frames - 1) && (k == rows - 1));
      case ($urandom_range(9))
        0: frame_id = FRAME_BITS'($urandom);
        1: frame_id = (frame_id != first_id) ? first_id : frame_id + FRAME_BITS'(1);
        default: frame_id = frame_id + FRAME_BITS'(1);
      endcase
    end
  endtask

  // Let everything queued drain: all rows taken, every readout seen, then
  // a pause long enough for the block to be idle again.
  task automatic wait_drained();
    while (pending_rows.size() != 0 || start_i || mode_readouts_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register writes happen only while the block is idle, so our copy of the
  // registers can follow them at once.
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == REG_THRESHOLD) label_threshold = data;
    else label_above = data[0];
  endtask

  task automatic run_phase(input logic [VALUE_BITS-1:0] threshold, input logic above,
                           input int unsigned idle_pct);
    wait_drained();
    write_reg(REG_THRESHOLD, threshold);
    write_reg(REG_COMPARE, CFG_DATA_BITS'(above));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
    sender_idle_pct = idle_pct;
    rows_built = 0;
    while (rows_built < ROWS_PER_PHASE) build_table($urandom_range(1, 8));
  endtask

  initial begin
    clear_run_state();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed tables at the reset settings (threshold zero, greater-than).
    // A single-row table whose value equals the threshold: one empty frame.
    queue_row('0, '0, 1'b1);
    // A single-row table at the largest id and value: one frame of count one.
    queue_row('1, '1, 1'b1);
    // Counts 2, 0, 2, 1, where the first id comes back after another frame
    // and must count as a frame of its own.
    queue_row('0, 16'h0001, 1'b0);
    queue_row('0, 16'h0001, 1'b0);
    queue_row(24'h5A5A5A, '0, 1'b0);
    queue_row('0, '1, 1'b0);
    queue_row('0, 16'h8000, 1'b0);
    queue_row(24'hA5A5A5, 16'h0001, 1'b1);

    // The at-most compare, with values on both sides of a small threshold.
    // Counts 1 and 2 tie at one frame each, and the larger count wins.
    wait_drained();
    write_reg(REG_THRESHOLD, 16'h0010);
    write_reg(REG_COMPARE, CFG_DATA_BITS'(1'b0));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
    queue_row(24'h000001, 16'h0010, 1'b0);
    queue_row(24'h000001, 16'h0011, 1'b0);
    queue_row(24'h000002, 16'h000F, 1'b0);
    queue_row(24'h000002, '0, 1'b1);

    // Random phases through the extremes of both registers and some middle
    // thresholds, with and without gaps from the sender.
    run_phase('1, 1'b0, 0);
    run_phase(VALUE_BITS'($urandom), 1'b1, 52);
    run_phase('1, 1'b1, 0);
    run_phase('0, 1'b0, 20);
    run_phase(VALUE_BITS'($urandom), 1'b0, 52);
    run_phase('0, 1'b1, 20);
    wait_drained();

    $display("checked %0d table readouts (%0d with count overflow) from %0d rows",
             readouts_checked, overflow_readouts, rows_accepted);
    $display("under %0d register settings, %0d mismatches", settings_used, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/fchm_pkg.sv
rtl/fchm_hist_mem.sv
rtl/fchm_mode_scan.sv
rtl/frame_count_histogram_mode.sv
tb/testbench.sv
